FILE: sv/lsm_pkg.sv
`timescale 1ns / 1ps

package lsm_pkg;

  typedef enum logic [2:0] {
    CMD_LB  = 3'd0,
    CMD_LH  = 3'd1,
    CMD_LW  = 3'd2,
    CMD_LBU = 3'd3,
    CMD_LHU = 3'd4,
    CMD_SB  = 3'd5,
    CMD_SH  = 3'd6,
    CMD_SW  = 3'd7
  } cmd_e;

  localparam int unsigned LANES = 4;

  localparam logic [1:0] MASK_NONE = 2'h0;
  localparam logic [1:0] MASK_HALF = 2'h1;
  localparam logic [1:0] MASK_WORD = 2'h3;

  // register select is paddr[2]
  localparam logic REG_CHECK_ALIGN = 1'b0;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] address;
    logic [31:0] store_data;
  } req_t;

  typedef struct packed {
    logic [31:0] load_data;
    logic        align_err;
  } rsp_t;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [29:0] row;
    logic [7:0]  wdata;
  } lane_ctl_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [1:0] offset;
    logic       fault;
    logic [3:0] lane_rd;
  } meta_t;

endpackage

FILE: sv/rv32_load_store_memory.sv
`timescale 1ns / 1ps

// Byte-addressed little-endian RV32I data memory held in four byte-lane
// memories, one request per clock cycle while busy is low. A request is
// taken when start is high and busy is low; its result appears on rsp_o
// with done_o high for exactly one cycle, the cycle after acceptance, and
// must be taken then, as the receiver cannot stall it. The result comes
// from the registered read of the lane memories; all four lanes are read or
// written in parallel, so a misaligned access that spans two words is still
// a single request. After reset the block clears its memory one row of four
// bytes a cycle, holding busy high; configuration writes are taken during
// that pass. check_alignment sits at byte address 0 of the APB-style port.
module rv32_load_store_memory #(
  parameter int unsigned MEM_BYTES = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  lsm_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output lsm_pkg::rsp_t rsp_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned Rows = (MEM_BYTES + 3) / 4;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [RowW-1:0] LastRow = RowW'(Rows - 1);

  logic               accept;
  logic               check_q;
  logic               clearing_q;
  logic [RowW-1:0]    clr_q;
  logic               done_q;
  lsm_pkg::meta_t     meta_q, meta_d;
  lsm_pkg::lane_ctl_t lane [lsm_pkg::LANES];
  logic               fault;
  logic [7:0]         rdata [lsm_pkg::LANES];
  logic [7:0]         byte_w[lsm_pkg::LANES];
  logic [1:0]         sel   [lsm_pkg::LANES];
  logic [31:0]        raw;
  logic [31:0]        load_data;

  assign busy   = clearing_q;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lsm_pkg::REG_CHECK_ALIGN) ? {31'b0, check_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lsm_pkg::REG_CHECK_ALIGN) begin
      check_q <= pwdata[0];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + RowW'(1);
      if (clr_q == LastRow) begin
        clearing_q <= 1'b0;
      end
    end
  end

  lsm_lane_map #(
    .MemBytes(MEM_BYTES)
  ) u_lane_map (
    .req_i        (req_i),
    .check_align_i(check_q),
    .lane_o       (lane),
    .fault_o      (fault)
  );

  for (genvar l = 0; l < lsm_pkg::LANES; l++) begin : g_lane
    lsm_bank #(
      .Depth(Rows),
      .RowW (RowW)
    ) u_bank (
      .clk_i  (clk_i),
      .en_i   (clearing_q || (accept && (lane[l].rd || lane[l].wr))),
      .we_i   (clearing_q || lane[l].wr),
      .addr_i (clearing_q ? clr_q : lane[l].row[RowW-1:0]),
      .wdata_i(clearing_q ? 8'h00 : lane[l].wdata),
      .rdata_o(rdata[l])
    );
  end

  always_comb begin
    meta_d.cmd     = req_i.cmd;
    meta_d.offset  = req_i.address[1:0];
    meta_d.fault   = fault;
    meta_d.lane_rd = {lane[3].rd, lane[2].rd, lane[1].rd, lane[0].rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      meta_q <= meta_d;
    end
  end

  always_comb begin
    for (int k = 0; k < lsm_pkg::LANES; k++) begin
      sel[k]    = meta_q.offset + 2'(k);
      byte_w[k] = meta_q.lane_rd[sel[k]] ? rdata[sel[k]] : 8'h00;
    end
    raw = {byte_w[3], byte_w[2], byte_w[1], byte_w[0]};
    case (meta_q.cmd)
      lsm_pkg::CMD_LB:  load_data = {{24{raw[7]}}, raw[7:0]};
      lsm_pkg::CMD_LH:  load_data = {{16{raw[15]}}, raw[15:0]};
      lsm_pkg::CMD_LW:  load_data = raw;
      lsm_pkg::CMD_LBU: load_data = {24'b0, raw[7:0]};
      lsm_pkg::CMD_LHU: load_data = {16'b0, raw[15:0]};
      default:          load_data = 32'b0;
    endcase
    if (meta_q.fault) begin
      load_data = 32'b0;
    end
  end

  assign done_o          = done_q;
  assign rsp_o.load_data = load_data;
  assign rsp_o.align_err = meta_q.fault;

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted request gave no result");

  a_fault_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && meta_q.fault |-> meta_q.lane_rd == 4'b0000 && rsp_o.load_data == 32'b0)
    else $error("faulted load read memory");

  a_store_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && (meta_q.cmd == lsm_pkg::CMD_SB || meta_q.cmd == lsm_pkg::CMD_SH ||
               meta_q.cmd == lsm_pkg::CMD_SW)
    |-> rsp_o.load_data == 32'b0 && !rsp_o.align_err)
    else $error("store returned data or fault");

  a_clear_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_q) == LastRow)
    else $error("clearing pass ended early");

endmodule

FILE: sv/lsm_bank.sv
`timescale 1ns / 1ps

module lsm_bank #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned RowW  = 10
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            we_i,
  input  logic [RowW-1:0] addr_i,
  input  logic [7:0]      wdata_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lsm_lane_map.sv
`timescale 1ns / 1ps

module lsm_lane_map #(
  parameter int unsigned MemBytes = 4096
) (
  input  lsm_pkg::req_t     req_i,
  input  logic              check_align_i,
  output lsm_pkg::lane_ctl_t lane_o [lsm_pkg::LANES],
  output logic              fault_o
);

  logic        is_load;
  logic [2:0]  count;
  logic [1:0]  mask;
  logic        fault;
  logic [1:0]  k    [lsm_pkg::LANES];
  logic [31:0] baddr[lsm_pkg::LANES];
  logic        inr  [lsm_pkg::LANES];
  logic        used [lsm_pkg::LANES];

  always_comb begin
    case (req_i.cmd)
      lsm_pkg::CMD_LB, lsm_pkg::CMD_LBU: begin
        is_load = 1'b1; count = 3'd1; mask = lsm_pkg::MASK_NONE;
      end
      lsm_pkg::CMD_LH, lsm_pkg::CMD_LHU: begin
        is_load = 1'b1; count = 3'd2; mask = lsm_pkg::MASK_HALF;
      end
      lsm_pkg::CMD_LW: begin
        is_load = 1'b1; count = 3'd4; mask = lsm_pkg::MASK_WORD;
      end
      lsm_pkg::CMD_SB: begin
        is_load = 1'b0; count = 3'd1; mask = lsm_pkg::MASK_NONE;
      end
      lsm_pkg::CMD_SH: begin
        is_load = 1'b0; count = 3'd2; mask = lsm_pkg::MASK_NONE;
      end
      default: begin
        is_load = 1'b0; count = 3'd4; mask = lsm_pkg::MASK_NONE;
      end
    endcase

    fault = is_load && check_align_i && ((req_i.address[1:0] & mask) != 2'b00);

    for (int l = 0; l < lsm_pkg::LANES; l++) begin
      // byte k of the access lands in lane l
      k[l]     = 2'(l) - req_i.address[1:0];
      baddr[l] = req_i.address + {30'b0, k[l]};
      inr[l]   = baddr[l] < 32'(MemBytes);
      used[l]  = {1'b0, k[l]} < count;
      lane_o[l].rd    = is_load && used[l] && inr[l] && !fault;
      lane_o[l].wr    = !is_load && used[l] && inr[l];
      lane_o[l].row   = baddr[l][31:2];
      lane_o[l].wdata = req_i.store_data[{k[l], 3'b000} +: 8];
    end
  end

  assign fault_o = fault;

endmodule

FILE: tb/tb_rv32_load_store_memory.sv
`timescale 1ns / 1ps

module tb_rv32_load_store_memory;

  localparam int unsigned MEM_BYTES = 4096;
  localparam logic [2:0] ALIGN_ADDR = {lsm_pkg::REG_CHECK_ALIGN, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = {~lsm_pkg::REG_CHECK_ALIGN, 2'b00};

  class lsu_scoreboard;
    logic [7:0]     mem_bytes [MEM_BYTES];
    logic           check_align;
    lsm_pkg::rsp_t  expected_q [$];
    int unsigned    requests, results, loads, stores, faults, mismatches;

    function new();
      foreach (mem_bytes[i]) mem_bytes[i] = 8'h00;
      check_align = 1'b0;
      requests = 0;
      results = 0;
      loads = 0;
      stores = 0;
      faults = 0;
      mismatches = 0;
    endfunction

    function logic [7:0] byte_at(logic [31:0] addr);
      if (addr < MEM_BYTES) return mem_bytes[addr];
      return 8'h00;
    endfunction

    function logic [31:0] fetch(logic [31:0] addr, int unsigned count);
      logic [31:0] value;
      value = '0;
      for (int unsigned k = 0; k < count; k++) value[8*k +: 8] = byte_at(addr + k);
      return value;
    endfunction

    function void put(logic [31:0] addr, logic [31:0] data, int unsigned count);
      logic [31:0] a;
      for (int unsigned k = 0; k < count; k++) begin
        a = addr + k;
        if (a < MEM_BYTES) mem_bytes[a] = data[8*k +: 8];
      end
    endfunction

    function void write_register(logic sel, logic [31:0] value);
      if (sel == lsm_pkg::REG_CHECK_ALIGN) check_align = value[0];
    endfunction

    function void check_register(logic sel, logic [31:0] got);
      if (sel == lsm_pkg::REG_CHECK_ALIGN && got !== {31'b0, check_align}) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: check_alignment read back %h, expected %h", $time, got,
                   {31'b0, check_align});
      end
    endfunction

    function void note_request(lsm_pkg::req_t r);
      lsm_pkg::rsp_t exp;
      logic [1:0]    mask;
      logic [31:0]   value;
      logic          is_load;
      exp = '0;
      requests++;
      is_load = r.cmd inside {lsm_pkg::CMD_LB, lsm_pkg::CMD_LH, lsm_pkg::CMD_LW,
                              lsm_pkg::CMD_LBU, lsm_pkg::CMD_LHU};
      case (r.cmd)
        lsm_pkg::CMD_LH, lsm_pkg::CMD_LHU: mask = lsm_pkg::MASK_HALF;
        lsm_pkg::CMD_LW:                   mask = lsm_pkg::MASK_WORD;
        default:                           mask = lsm_pkg::MASK_NONE;
      endcase
      if (is_load) loads++;
      else stores++;
      if (is_load && check_align && (r.address[1:0] & mask) != 2'b00) begin
        exp.align_err = 1'b1;
        faults++;
      end else begin
        case (r.cmd)
          lsm_pkg::CMD_LB: begin
            value = fetch(r.address, 1);
            exp.load_data = {{24{value[7]}}, value[7:0]};
          end
          lsm_pkg::CMD_LH: begin
            value = fetch(r.address, 2);
            exp.load_data = {{16{value[15]}}, value[15:0]};
          end
          lsm_pkg::CMD_LW:  exp.load_data = fetch(r.address, 4);
          lsm_pkg::CMD_LBU: exp.load_data = fetch(r.address, 1);
          lsm_pkg::CMD_LHU: exp.load_data = fetch(r.address, 2);
          lsm_pkg::CMD_SB:  put(r.address, r.store_data, 1);
          lsm_pkg::CMD_SH:  put(r.address, r.store_data, 2);
          default:          put(r.address, r.store_data, 4);
        endcase
      end
      expected_q.push_back(exp);
    endfunction

    function void report(string what, lsm_pkg::rsp_t exp, lsm_pkg::rsp_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected load_data %h fault %b, got load_data %h fault %b",
                 $time, what, exp.load_data, exp.align_err, got.load_data,
                 got.align_err);
    endfunction

    function void check_response(lsm_pkg::rsp_t got);
      lsm_pkg::rsp_t exp;
      results++;
      if (expected_q.size() == 0) begin
        report("result with no request pending", '0, got);
      end else begin
        exp = expected_q.pop_front();
        if (got.load_data !== exp.load_data || got.align_err !== exp.align_err)
          report("wrong result", exp, got);
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  lsm_pkg::req_t req_i = '0;
  logic          busy;
  logic          done_o;
  lsm_pkg::rsp_t rsp_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  lsu_scoreboard sb;

  rv32_load_store_memory #(
    .MEM_BYTES(MEM_BYTES)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .rsp_o  (rsp_o),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_response(rsp_o);
      if (start && !busy) sb.note_request(req_i);
      if (psel && penable && pready) begin
        if (pwrite) sb.write_register(paddr[2], pwdata);
        else sb.check_register(paddr[2], prdata);
      end
    end
  end

  task automatic apb_access(input logic is_write, input logic [2:0] addr,
                            input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic issue(input lsm_pkg::cmd_e c, input logic [31:0] addr,
                       input logic [31:0] data);
    start <= 1'b1;
    req_i <= '{cmd: c, address: addr, store_data: data};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic idle(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_alignment(input logic on);
    logic [31:0] value;
    value = $urandom();
    value[0] = on;
    drain();
    apb_access(1'b1, ALIGN_ADDR, value);
    apb_access(1'b0, ALIGN_ADDR, '0);
  endtask

  function automatic logic [31:0] random_address();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return $urandom_range(0, 255);
    if (pick < 14) return MEM_BYTES - 8 + $urandom_range(0, 15);
    if (pick < 15) return 32'hFFFF_FFF8 + $urandom_range(0, 7);
    if (pick < 17) return $urandom_range(0, MEM_BYTES - 1);
    return $urandom();
  endfunction

  task automatic run_phase(input int unsigned count, input int unsigned gap_pct);
    int unsigned sent;
    logic [31:0] addr;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < gap_pct) idle($urandom_range(1, 7));
      if (gap_pct != 0 && $urandom_range(0, 199) == 0) drain();
      addr = random_address();
      if ($urandom_range(0, 2) == 0) begin
        // store, then read back around it
        issue(lsm_pkg::cmd_e'(3'($urandom_range(lsm_pkg::CMD_SB, lsm_pkg::CMD_SW))),
              addr, $urandom());
        issue(lsm_pkg::cmd_e'(3'($urandom_range(lsm_pkg::CMD_LB, lsm_pkg::CMD_LHU))),
              addr + $urandom_range(0, 3), $urandom());
        sent += 2;
      end else begin
        issue(lsm_pkg::cmd_e'(3'($urandom_range(lsm_pkg::CMD_LB, lsm_pkg::CMD_SW))),
              addr, $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    apb_access(1'b1, ALIGN_ADDR, 32'h0000_0000);
    apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_FFFF);
    apb_access(1'b0, ALIGN_ADDR, '0);

    // unchecked: sign handling, misaligned, end of memory, address wrap
    issue(lsm_pkg::CMD_SW, 32'h0, 32'h80FF_7F01);
    issue(lsm_pkg::CMD_LB, 32'h0, 32'h0);
    issue(lsm_pkg::CMD_LB, 32'h1, 32'h0);
    issue(lsm_pkg::CMD_LB, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LBU, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LH, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LHU, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LH, 32'h1, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'h0, 32'h0);
    issue(lsm_pkg::CMD_SW, MEM_BYTES - 2, 32'hA5A5_5A5A);
    issue(lsm_pkg::CMD_LW, MEM_BYTES - 2, 32'h0);
    issue(lsm_pkg::CMD_LW, MEM_BYTES - 4, 32'h0);
    issue(lsm_pkg::CMD_SW, 32'hFFFF_FFFE, 32'h1234_5678);
    issue(lsm_pkg::CMD_LW, 32'hFFFF_FFFE, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    issue(lsm_pkg::CMD_SB, 32'h3, 32'hFFFF_FF00);
    issue(lsm_pkg::CMD_SH, 32'h5, 32'h0000_8001);
    issue(lsm_pkg::CMD_LHU, 32'h5, 32'h0);

    // checked: misaligned loads fault, bytes and stores never do
    set_alignment(1'b1);
    issue(lsm_pkg::CMD_LH, 32'h1, 32'h0);
    issue(lsm_pkg::CMD_LHU, 32'h3, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'h1, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'h3, 32'h0);
    issue(lsm_pkg::CMD_LB, 32'h1, 32'h0);
    issue(lsm_pkg::CMD_LBU, 32'h3, 32'h0);
    issue(lsm_pkg::CMD_SH, 32'h1, 32'h0000_BEEF);
    issue(lsm_pkg::CMD_SW, 32'h6, 32'hDEAD_C0DE);
    issue(lsm_pkg::CMD_LH, 32'h2, 32'h0);
    issue(lsm_pkg::CMD_LW, 32'h4, 32'h0);

    run_phase(480, 25);
    set_alignment(1'b0);
    run_phase(480, 35);
    set_alignment($urandom_range(0, 1));
    run_phase(480, 15);
    set_alignment(1'b1);
    run_phase(480, 0);

    drain();
    repeat (4) @(posedge clk_i);
    $display("%0d requests, %0d results: %0d loads, %0d stores, %0d alignment faults",
             sb.requests, sb.results, sb.loads, sb.stores, sb.faults);
    $display("check_alignment run off and on, unmapped register write, %0d errors",
             sb.mismatches + sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
